/* rtl/core/tae_pkg.sv */
// shared types and constants for the triangle distortion energy core
package tae_pkg;

  // raw field widths
  localparam int unsigned CoordW  = 32;
  localparam int unsigned EnergyW = 48;

  // internal widths of the datapath
  localparam int unsigned DetMagW = 66;  // magnitude of the determinant
  localparam int unsigned NumW    = 70;  // weighted sum of squared edges
  localparam int unsigned HalfW   = 35;  // split point of the constant multiply
  localparam int unsigned KW      = 31;  // width of the scale constant
  localparam int unsigned DvdW    = 86;  // dividend after the common shift
  localparam int unsigned QuotW   = 48;  // quotient bits produced

  // round(2^32 / (2 sqrt3)) in unsigned q0.32
  localparam logic [KW-1:0] InvTwoSqrt3 = 31'd1239850262;

  localparam logic [EnergyW-1:0] EnergyMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [EnergyW-1:0] EnergyMin = 48'h8000_0000_0000;

  // flags that travel alongside each request
  typedef struct packed {
    logic valid;
    logic degen;
    logic dneg;
    logic sat;
  } side_t;

endpackage

/* rtl/core/tae_if.sv */
// request and result channel interfaces of the energy core
interface tae_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] p0_x;
  logic signed [31:0] p0_y;
  logic signed [31:0] p1_x;
  logic signed [31:0] p1_y;
  logic signed [31:0] p2_x;
  logic signed [31:0] p2_y;

  modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, input ready);
  modport sink (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, output ready);
endinterface

interface tae_out_if;
  logic valid;
  logic ready;
  logic signed [47:0] energy;
  logic degenerate;
  logic saturated;

  modport source (output valid, energy, degenerate, saturated, input ready);
  modport sink (input valid, energy, degenerate, saturated, output ready);
endinterface

/* rtl/core/triangle_amips_energy_core.sv */
// top level of the 2d triangle distortion energy core
//
// One request carries the three corners of a triangle in signed q16.16
// on in_i; one result per request leaves on out_o as a signed q32.16
// energy with a degenerate flag and a saturated flag. Both channels use
// a valid/ready handshake; a transfer happens on a clock edge with both
// high.
// The core is a single pipeline: five stages form edges, products, the
// determinant, the scaled numerator and the dividend, then a 49-stage
// divider (an overflow check, then one quotient bit per stage) follows,
// and an output register applies sign, saturation limits and flags. A
// new request is taken every cycle unless out_o stalls.
// When out_o stalls with a result waiting, the whole pipeline holds and
// in_i.ready drops; nothing is lost or repeated. Reset clears all valid
// bits, so the pipeline comes up empty and ready at once.
module triangle_amips_energy_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  tae_in_if.sink    in_i,
  tae_out_if.source out_o
);

  localparam int unsigned DW = tae_pkg::DetMagW;
  localparam int unsigned NW = tae_pkg::NumW;
  localparam int unsigned HW = tae_pkg::HalfW;
  localparam int unsigned PW = tae_pkg::HalfW + tae_pkg::KW;

  logic en;
  logic out_valid_q;

  // pipeline advances whenever the output register can take a result
  assign en = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // stage 1: edge vectors
  logic signed [32:0] a_d, b_d, c_d, d_d;
  logic signed [34:0] u_d, v_d;
  logic signed [32:0] a_q, b_q, c_q, d_q;
  logic signed [34:0] u_q, v_q;
  logic v1_q;

  always_comb begin
    a_d = {in_i.p1_x[31], in_i.p1_x} - {in_i.p0_x[31], in_i.p0_x};
    b_d = {in_i.p1_y[31], in_i.p1_y} - {in_i.p0_y[31], in_i.p0_y};
    c_d = {in_i.p2_x[31], in_i.p2_x} - {in_i.p0_x[31], in_i.p0_x};
    d_d = {in_i.p2_y[31], in_i.p2_y} - {in_i.p0_y[31], in_i.p0_y};
    u_d = {c_d[32], c_d, 1'b0} - {{2{a_d[32]}}, a_d};
    v_d = {d_d[32], d_d, 1'b0} - {{2{b_d[32]}}, b_d};
  end

  // stage 2: products and squares
  logic signed [65:0] ad_w, bc_w, a2_w, b2_w;
  logic signed [69:0] u2_w, v2_w;
  logic signed [65:0] ad_q, bc_q;
  logic [63:0] a2_q, b2_q;
  logic [67:0] u2_q, v2_q;
  logic v2v_q;

  always_comb begin
    ad_w = a_q * d_q;
    bc_w = b_q * c_q;
    a2_w = a_q * a_q;
    b2_w = b_q * b_q;
    u2_w = u_q * u_q;
    v2_w = v_q * v_q;
  end

  // stage 3: determinant and weighted numerator
  logic signed [66:0] det_d, det_q;
  logic [NW-1:0] sq_w, num_d, num_q;
  logic v3_q;

  always_comb begin
    det_d = {ad_q[65], ad_q} - {bc_q[65], bc_q};
    sq_w  = {{(NW-64){1'b0}}, a2_q} + {{(NW-64){1'b0}}, b2_q};
    num_d = {sq_w[NW-2:0], 1'b0} + sq_w + {{(NW-68){1'b0}}, u2_q}
          + {{(NW-68){1'b0}}, v2_q};
  end

  // stage 4: determinant magnitude, split constant multiply
  logic [66:0] det_neg_w;
  logic [DW-1:0] detm_d, detm4_q;
  logic [PW-1:0] plo_d, phi_d, plo_q, phi_q;
  tae_pkg::side_t side4_d, side4_q;

  always_comb begin
    det_neg_w = -det_q;
    detm_d = det_q[66] ? det_neg_w[DW-1:0] : det_q[DW-1:0];
    plo_d  = num_q[HW-1:0] * tae_pkg::InvTwoSqrt3;
    phi_d  = num_q[NW-1:HW] * tae_pkg::InvTwoSqrt3;
    side4_d.valid = v3_q;
    side4_d.degen = det_q == '0;
    side4_d.dneg  = det_q[66];
    side4_d.sat   = 1'b0;
  end

  // stage 5: dividend with the half-up rounding term, common 2^17 removed
  logic [PW+HW-1:0] nk_w;
  logic [102:0] n_w;
  logic [tae_pkg::DvdW-1:0] dvd_q;
  logic [DW-1:0] detm5_q;
  tae_pkg::side_t side5_q;

  always_comb begin
    nk_w = {phi_q, {HW{1'b0}}} + {{HW{1'b0}}, plo_q};
    n_w  = {1'b0, nk_w, 1'b0} + {{(103-DW-16){1'b0}}, detm4_q, 16'b0};
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2v_q   <= 1'b0;
      v3_q    <= 1'b0;
      side4_q <= '0;
      side5_q <= '0;
    end else if (en) begin
      v1_q    <= in_i.valid;
      v2v_q   <= v1_q;
      v3_q    <= v2v_q;
      side4_q <= side4_d;
      side5_q <= side4_q;
    end
  end

  // datapath registers of the front stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;
      b_q <= b_d;
      c_q <= c_d;
      d_q <= d_d;
      u_q <= u_d;
      v_q <= v_d;
      ad_q <= ad_w;
      bc_q <= bc_w;
      a2_q <= a2_w[63:0];
      b2_q <= b2_w[63:0];
      u2_q <= u2_w[67:0];
      v2_q <= v2_w[67:0];
      det_q <= det_d;
      num_q <= num_d;
      detm4_q <= detm_d;
      plo_q <= plo_d;
      phi_q <= phi_d;
      detm5_q <= detm4_q;
      dvd_q <= n_w[102:17];
    end
  end

  // divider
  tae_pkg::side_t side_div;
  logic [tae_pkg::QuotW-1:0] quot;

  tae_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (side5_q),
    .dvd_i  (dvd_q),
    .dvs_i  (detm5_q),
    .side_o (side_div),
    .quot_o (quot)
  );

  // output stage: sign, limits and flags
  logic [tae_pkg::EnergyW-1:0] energy_d, energy_q;
  logic degen_d, degen_q, sat_d, sat_q;

  always_comb begin
    degen_d  = 1'b0;
    sat_d    = 1'b0;
    energy_d = quot;
    if (side_div.degen) begin
      degen_d  = 1'b1;
      energy_d = tae_pkg::EnergyMax;
    end else if (!side_div.dneg) begin
      if (side_div.sat || quot[tae_pkg::QuotW-1]) begin
        sat_d    = 1'b1;
        energy_d = tae_pkg::EnergyMax;
      end
    end else begin
      if (side_div.sat || quot > tae_pkg::EnergyMin) begin
        sat_d    = 1'b1;
        energy_d = tae_pkg::EnergyMin;
      end else begin
        energy_d = -quot;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= side_div.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      energy_q <= energy_d;
      degen_q  <= degen_d;
      sat_q    <= sat_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.energy     = energy_q;
  assign out_o.degenerate = degen_q;
  assign out_o.saturated  = sat_q;

endmodule

/* rtl/core/tae_divider.sv */
// pipelined restoring divider, one quotient bit per stage
module tae_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  tae_pkg::side_t              side_i,
  input  logic [tae_pkg::DvdW-1:0]    dvd_i,
  input  logic [tae_pkg::DetMagW-1:0] dvs_i,
  output tae_pkg::side_t              side_o,
  output logic [tae_pkg::QuotW-1:0]   quot_o
);

  localparam int unsigned QW = tae_pkg::QuotW;
  localparam int unsigned DW = tae_pkg::DetMagW;
  localparam int unsigned HW = tae_pkg::DvdW - tae_pkg::QuotW;

  tae_pkg::side_t  side_q [0:QW];
  logic [DW-1:0]   rem_q  [0:QW];
  logic [DW-1:0]   dvs_q  [0:QW];
  logic [QW-1:0]   low_q  [0:QW];
  logic [QW-1:0]   quo_q  [0:QW];

  // entry stage: overflow check on the top dividend bits
  logic [DW-1:0] top_w;
  tae_pkg::side_t side_w;
  always_comb begin
    top_w = {{(DW-HW){1'b0}}, dvd_i[tae_pkg::DvdW-1:QW]};
    side_w = side_i;
    side_w.sat = top_w >= dvs_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q[0] <= '0;
    end else if (en_i) begin
      side_q[0] <= side_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= top_w;
      dvs_q[0] <= dvs_i;
      low_q[0] <= dvd_i[QW-1:0];
      quo_q[0] <= '0;
    end
  end

  // one shift, compare and subtract per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      trial = {rem_q[k], low_q[k][QW-1]};
      diff  = trial - {1'b0, dvs_q[k]};
      ge    = trial >= {1'b0, dvs_q[k]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k+1] <= '0;
      end else if (en_i) begin
        side_q[k+1] <= side_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        dvs_q[k+1] <= dvs_q[k];
        low_q[k+1] <= {low_q[k][QW-2:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][QW-2:0], ge};
      end
    end
  end

  assign side_o = side_q[QW];
  assign quot_o = quo_q[QW];

endmodule

/* sim/triangle_amips_energy_core_test.sv */
// testbench for the triangle distortion energy core: random and directed triangles
`timescale 1ns / 100ps

module triangle_amips_energy_core_test;

  typedef struct packed {
    logic signed [31:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y;
  } tri_t;

  typedef struct packed {
    logic [47:0] energy;
    logic        degenerate;
    logic        saturated;
  } energy_t;

  localparam logic [31:0] KScale = 32'd1239850262;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tae_in_if  req_if ();
  tae_out_if res_if ();

  triangle_amips_energy_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if.sink),
    .out_o  (res_if.source)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  tri_t    pending_q[$];
  energy_t expected_q[$];
  int      n_fail = 0;
  int      n_sent = 0;
  int      n_got = 0;
  int      n_degen = 0;
  int      n_sat = 0;
  int      n_neg = 0;
  bit      hold_off = 1'b0;
  bit      stim_done = 1'b0;

  // exact energy of one triangle
  function automatic energy_t amips_energy(tri_t t);
    logic signed [33:0]  a, b, c, d;
    logic signed [35:0]  u, v;
    logic signed [71:0]  det;
    logic        [71:0]  detm;
    logic        [127:0] num, nk, dm, quo;
    energy_t r;
    a = 34'(t.p1_x) - 34'(t.p0_x);
    b = 34'(t.p1_y) - 34'(t.p0_y);
    c = 34'(t.p2_x) - 34'(t.p0_x);
    d = 34'(t.p2_y) - 34'(t.p0_y);
    u = 36'(c) * 2 - 36'(a);
    v = 36'(d) * 2 - 36'(b);
    det = 72'(a) * 72'(d) - 72'(b) * 72'(c);
    r = '0;
    if (det == 0) begin
      r.energy = tae_pkg::EnergyMax;
      r.degenerate = 1'b1;
      return r;
    end
    detm = det < 0 ? 72'(-det) : 72'(det);
    num = 128'(72'(a) * 72'(a) + 72'(b) * 72'(b)) * 3
        + 128'(72'(u) * 72'(u)) + 128'(72'(v) * 72'(v));
    nk = num * 128'(KScale);
    dm = 128'(detm) << 16;
    quo = ((nk << 1) + dm) / (dm << 1);
    if (det > 0) begin
      if (quo > 128'(tae_pkg::EnergyMax)) begin
        r.energy = tae_pkg::EnergyMax;
        r.saturated = 1'b1;
      end else r.energy = quo[47:0];
    end else begin
      if (quo > 128'(tae_pkg::EnergyMin)) begin
        r.energy = tae_pkg::EnergyMin;
        r.saturated = 1'b1;
      end else r.energy = 48'(-quo);
    end
    return r;
  endfunction

  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    n_fail++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return 32'($signed($urandom_range(0, 200000)) - 100000);
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 65536 * 64)) - 65536 * 32);
    endcase
  endfunction

  function automatic tri_t make_tri(logic [31:0] x0, logic [31:0] y0, logic [31:0] x1,
                                    logic [31:0] y1, logic [31:0] x2, logic [31:0] y2);
    tri_t t;
    t.p0_x = x0; t.p0_y = y0; t.p1_x = x1; t.p1_y = y1; t.p2_x = x2; t.p2_y = y2;
    return t;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // request driver
  int src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    tri_t t;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      src_gap = 0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) n_sent++;
      if (src_gap > 0) begin
        src_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_q.size() > 0 && !hold_off) begin
        t = pending_q.pop_front();
        expected_q.push_back(amips_energy(t));
        req_if.valid <= 1'b1;
        req_if.p0_x <= t.p0_x; req_if.p0_y <= t.p0_y;
        req_if.p1_x <= t.p1_x; req_if.p1_y <= t.p1_y;
        req_if.p2_x <= t.p2_x; req_if.p2_y <= t.p2_y;
        src_gap = gap_len();
      end else req_if.valid <= 1'b0;
    end
  end

  // result monitor and stall generator
  int sink_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    energy_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        n_got++;
        if (expected_q.size() == 0) report("unexpected result", res_if.energy, '0);
        else begin
          want = expected_q.pop_front();
          if (res_if.energy !== want.energy) report("energy", res_if.energy, want.energy);
          if (res_if.degenerate !== want.degenerate)
            report("degenerate", 48'(res_if.degenerate), 48'(want.degenerate));
          if (res_if.saturated !== want.saturated)
            report("saturated", 48'(res_if.saturated), 48'(want.saturated));
          n_degen += want.degenerate;
          n_sat += want.saturated;
          n_neg += want.energy[47];
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        sink_gap = gap_len();
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [31:0] x0, y0, s;
    req_if.valid = 1'b0;
    req_if.p0_x = '0; req_if.p0_y = '0; req_if.p1_x = '0;
    req_if.p1_y = '0; req_if.p2_x = '0; req_if.p2_y = '0;
    res_if.ready = 1'b0;
    // unit right triangle, inverted copy, degenerate shapes and extreme corners
    pending_q.push_back(make_tri(0, 0, 32'h10000, 0, 0, 32'h10000));
    pending_q.push_back(make_tri(0, 0, 0, 32'h10000, 32'h10000, 0));
    pending_q.push_back(make_tri(0, 0, 0, 0, 0, 0));
    pending_q.push_back(make_tri(5, 7, 10, 14, 15, 21));
    pending_q.push_back(make_tri(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    pending_q.push_back(make_tri(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    // slivers drive positive and negative saturation; other shapes follow
    pending_q.push_back(make_tri(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 1));
    pending_q.push_back(make_tri(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF));
    pending_q.push_back(make_tri(0, 0, 1, 0, 0, 1));
    pending_q.push_back(make_tri(0, 0, 1, 0, 0, 32'hFFFF_FFFF));
    pending_q.push_back(make_tri(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_q.push_back(make_tri(0, 0, 32'h10000, 0, 32'h8000, 32'hDDB3));
    pending_q.push_back(make_tri(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA,
                                 32'h5555_5555, 32'h1234_5678, 32'h8765_4321));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < 1640; i++) begin
      if (i % 10 == 9) begin
        // degenerate: collinear or repeated corners
        x0 = rand_coord(); y0 = rand_coord();
        s = $urandom_range(0, 3);
        pending_q.push_back(make_tri(x0, y0, x0 + s, y0 + 2 * s, x0 + 3 * s, y0 + 6 * s));
      end else
        pending_q.push_back(make_tri(rand_coord(), rand_coord(), rand_coord(),
                                     rand_coord(), rand_coord(), rand_coord()));
      if (i == 600) begin
        // let the pipe drain completely once before continuing
        while (pending_q.size() > 0) @(posedge clk_i);
        hold_off = 1'b1;
        while (expected_q.size() > 0 || req_if.valid) @(posedge clk_i);
        hold_off = 1'b0;
      end
    end
    while (pending_q.size() > 0 || req_if.valid) @(posedge clk_i);
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("%0d triangles checked: %0d degenerate, %0d saturated, %0d inverted",
             n_got, n_degen, n_sat, n_neg);
    if (n_fail == 0 && expected_q.size() == 0) begin
      $display("triangle_amips_energy_core regression: pass");
    end else begin
      $display("triangle_amips_energy_core regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("triangle_amips_energy_core regression: fail");
    $finish;
  end

endmodule
